// ===== src/ssvs_pkg.sv =====
// Package for the sorted sparse vector store: word types, codes and defaults.
// Used by the channel interfaces and by the top level. No dependencies.
`default_nettype none

package ssvs_pkg;

    // Default sizing
    localparam int CAPACITY_DEF   = 64;
    localparam int INDEX_BITS_DEF = 16;

    // Fixed field widths
    localparam int ACTION_W  = 3;
    localparam int POSITION_W = 16;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int ECOUNT_W  = 7;
    localparam int DIM_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // Request codes
    localparam logic [ACTION_W-1:0] ACT_GET    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SET    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_SCALE = 1'b1;

    // Configuration reset values
    localparam logic [DIM_W-1:0]   DIMENSION_RST = 17'd65536;
    localparam logic [VALUE_W-1:0] ADD_SCALE_RST = 32'd65536;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [POSITION_W-1:0] position;
        logic signed [VALUE_W-1:0] operand;
    } ssvs_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic                      found;
        logic [STATUS_W-1:0]       status;
        logic [ECOUNT_W-1:0]       entry_count;
    } ssvs_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_ROUTE,
        S_MUL,
        S_SUM,
        S_PLACE,
        S_SHUP,
        S_SHDN,
        S_WRITE,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== src/ssvs_if.sv =====
// Valid/ready channel interfaces for request and result words.
// Depends on ssvs_pkg for the word types.
`default_nettype none

interface ssvs_req_if;
    import ssvs_pkg::*;

    logic      valid;
    logic      ready;
    ssvs_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ssvs_rsp_if;
    import ssvs_pkg::*;

    logic      valid;
    logic      ready;
    ssvs_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/sorted_sparse_vector_store_unit.sv =====
// Top level of the sorted sparse vector store: sequencer, pair memory, config.
// Depends on ssvs_pkg and the channel interfaces in ssvs_if.sv.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+--------------------------------------
//  req     | in  | valid/ready        | action, position, operand
//  rsp     | out | valid/ready        | read_value, found, status, entry_count
//  cfg     | in  | cfg_we, no ready   | cfg_index, cfg_data
//
// One request at a time. S_IDLE accepts it; each binary search probe is a memory
// read in S_PROBE, then a compare in S_CMP, and S_ROUTE then dispatches on the code.
// Scaled add passes through S_MUL (multiply) and S_SUM (saturating sum); set and
// add then place in S_PLACE. Pairs are moved one place through the memory, each
// read and then written back: an insert moves count-slot pairs and then writes the
// new pair in S_WRITE, a remove moves count-slot-1 pairs. S_FINISH loads the result
// once the result register is free; the next request is accepted while a result
// still waits. Reset zeroes the pair count but not the pair memory, which is never
// cleared, since only entries below the count are read.
`default_nettype none

module sorted_sparse_vector_store_unit #(
    parameter int CAPACITY   = ssvs_pkg::CAPACITY_DEF,
    parameter int INDEX_BITS = ssvs_pkg::INDEX_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ssvs_req_if.sink                            req,
    ssvs_rsp_if.source                          rsp,
    input  wire logic                           cfg_we,
    input  wire logic [ssvs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ssvs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssvs_pkg::*;

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ENTRY_W = INDEX_BITS + VALUE_W;
    localparam logic [63:0] KEY_MASK64 = (64'd1 << INDEX_BITS) - 64'd1;
    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);
    localparam logic [COUNT_W-1:0] ONE_COUNT = COUNT_W'(1);

    // Pair memory: {index, value}
    logic [ENTRY_W-1:0] pair_mem [CAPACITY];
    logic [ENTRY_W-1:0] rd_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata;

    // Sequencer and datapath registers
    state_t                 state_reg, state_next;
    logic [ACTION_W-1:0]    action_reg, action_next;
    logic [INDEX_BITS-1:0]  key_reg, key_next;
    logic [VALUE_W-1:0]     operand_reg, operand_next;
    logic [COUNT_W-1:0]     lo_reg, lo_next;
    logic [COUNT_W-1:0]     hi_reg, hi_next;
    logic [COUNT_W-1:0]     mid_reg, mid_next;
    logic [COUNT_W-1:0]     slot_reg, slot_next;
    logic                   found_reg, found_next;
    logic [VALUE_W-1:0]     old_reg, old_next;
    logic [VALUE_W-1:0]     nv_reg, nv_next;
    logic [VALUE_W-1:0]     res_reg, res_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic signed [63:0]     prod_reg, prod_next;
    logic [COUNT_W-1:0]     ptr_reg, ptr_next;
    logic [COUNT_W-1:0]     dst_reg, dst_next;
    logic [COUNT_W-1:0]     left_reg, left_next;
    logic                   pend_reg, pend_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [DIM_W-1:0]       dim_reg;
    logic [VALUE_W-1:0]     scale_reg;
    logic                   out_valid_reg, out_valid_next;
    ssvs_rsp_t              rsp_reg, rsp_next;

    // Request decode
    logic [POSITION_W-1:0]  pos_masked;
    logic                   out_of_range;
    logic [COUNT_W-1:0]     probe_mid;
    logic [INDEX_BITS-1:0]  rd_idx;
    logic [VALUE_W-1:0]     rd_val;
    logic signed [48:0]     sum_wide;
    logic [VALUE_W-1:0]     sum_sat;
    logic [31:0]            count32;

    assign pos_masked   = req.payload.position & KEY_MASK64[POSITION_W-1:0];
    assign out_of_range = {1'b0, pos_masked} >= dim_reg;
    assign probe_mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_idx       = rd_reg[ENTRY_W-1:VALUE_W];
    assign rd_val       = rd_reg[VALUE_W-1:0];
    assign count32      = 32'(count_reg);

    // Saturating sum of old value and floored product
    assign sum_wide = $signed({{17{old_reg[VALUE_W-1]}}, old_reg})
                    + $signed({prod_reg[63], prod_reg[63:16]});
    always_comb
    begin
        if (!sum_wide[48] && (|sum_wide[47:31]))
            sum_sat = 32'h7FFF_FFFF;
        else if (sum_wide[48] && !(&sum_wide[47:31]))
            sum_sat = 32'h8000_0000;
        else
            sum_sat = sum_wide[31:0];
    end

    // Hold the pair memory; read data registered every cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pair_mem[mem_waddr] <= mem_wdata;
        rd_reg <= pair_mem[mem_raddr];
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg   <= DIMENSION_RST;
            scale_reg <= ADD_SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIMENSION: dim_reg   <= cfg_data[DIM_W-1:0];
                CFG_ADD_SCALE: scale_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            left_reg      <= left_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        key_reg     <= key_next;
        operand_reg <= operand_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        slot_reg    <= slot_next;
        found_reg   <= found_next;
        old_reg     <= old_next;
        nv_reg      <= nv_next;
        res_reg     <= res_next;
        status_reg  <= status_next;
        prod_reg    <= prod_next;
        ptr_reg     <= ptr_next;
        dst_reg     <= dst_next;
        rsp_reg     <= rsp_next;
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    // Sequencer: next state, datapath updates, memory control
    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        key_next       = key_reg;
        operand_next   = operand_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        old_next       = old_reg;
        nv_next        = nv_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        prod_next      = prod_reg;
        ptr_next       = ptr_reg;
        dst_next       = dst_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mem_we         = 1'b0;
        mem_waddr      = dst_reg[ADDR_W-1:0];
        mem_wdata      = rd_reg;
        mem_raddr      = ptr_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    action_next  = req.payload.action;
                    key_next     = INDEX_BITS'(pos_masked);
                    operand_next = req.payload.operand;
                    found_next   = 1'b0;
                    old_next     = '0;
                    res_next     = '0;
                    status_next  = STATUS_OK;
                    lo_next      = '0;
                    hi_next      = count_reg;
                    if (req.payload.action == ACT_CLEAR)
                    begin
                        count_next = '0;
                        state_next = S_FINISH;
                    end
                    else if (out_of_range)
                    begin
                        status_next = STATUS_RANGE;
                        state_next  = S_FINISH;
                    end
                    else
                        state_next = S_PROBE;
                end
            end

            // Issue a probe read, or end the search at the insert place
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = probe_mid;
                    mem_raddr  = probe_mid[ADDR_W-1:0];
                    state_next = S_CMP;
                end
                else
                begin
                    slot_next  = lo_reg;
                    state_next = S_ROUTE;
                end
            end

            // Compare probed index against the key
            S_CMP:
            begin
                if (rd_idx < key_reg)
                begin
                    lo_next    = mid_reg + ONE_COUNT;
                    state_next = S_PROBE;
                end
                else if (rd_idx > key_reg)
                begin
                    hi_next    = mid_reg;
                    state_next = S_PROBE;
                end
                else
                begin
                    slot_next  = mid_reg;
                    found_next = 1'b1;
                    old_next   = rd_val;
                    state_next = S_ROUTE;
                end
            end

            // Dispatch on the request code
            S_ROUTE:
            begin
                case (action_reg)
                    ACT_SET:
                    begin
                        nv_next    = operand_reg;
                        state_next = S_PLACE;
                    end
                    ACT_ADD:
                        state_next = S_MUL;
                    ACT_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            ptr_next   = slot_reg + ONE_COUNT;
                            left_next  = count_reg - slot_reg - ONE_COUNT;
                            pend_next  = 1'b0;
                            state_next = S_SHDN;
                        end
                        else
                            state_next = S_FINISH;
                    end
                    default:
                    begin
                        res_next   = found_reg ? old_reg : '0;
                        state_next = S_FINISH;
                    end
                endcase
            end

            // Multiply scale by operand
            S_MUL:
            begin
                prod_next  = $signed({{32{scale_reg[VALUE_W-1]}}, scale_reg})
                           * $signed({{32{operand_reg[VALUE_W-1]}}, operand_reg});
                state_next = S_SUM;
            end

            // Floor the product to Q16.16 and add with saturation
            S_SUM:
            begin
                nv_next    = sum_sat;
                state_next = S_PLACE;
            end

            // Overwrite, reject as full, or open a gap
            S_PLACE:
            begin
                if (found_reg)
                    state_next = S_WRITE;
                else if (count_reg >= CAP_COUNT)
                begin
                    status_next = STATUS_FULL;
                    state_next  = S_FINISH;
                end
                else
                begin
                    ptr_next   = count_reg - ONE_COUNT;
                    left_next  = count_reg - slot_reg;
                    pend_next  = 1'b0;
                    state_next = S_SHUP;
                end
            end

            // Move pairs up one place, highest first
            S_SHUP:
            begin
                mem_we    = pend_reg;
                pend_next = 1'b0;
                if (left_reg != '0)
                begin
                    mem_raddr = ptr_reg[ADDR_W-1:0];
                    dst_next  = ptr_reg + ONE_COUNT;
                    ptr_next  = ptr_reg - ONE_COUNT;
                    left_next = left_reg - ONE_COUNT;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg + ONE_COUNT;
                    state_next = S_WRITE;
                end
            end

            // Move pairs down one place, lowest first
            S_SHDN:
            begin
                mem_we    = pend_reg;
                pend_next = 1'b0;
                if (left_reg != '0)
                begin
                    mem_raddr = ptr_reg[ADDR_W-1:0];
                    dst_next  = ptr_reg - ONE_COUNT;
                    ptr_next  = ptr_reg + ONE_COUNT;
                    left_next = left_reg - ONE_COUNT;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - ONE_COUNT;
                    state_next = S_FINISH;
                end
            end

            // Store the new pair at its slot
            S_WRITE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = slot_reg[ADDR_W-1:0];
                mem_wdata  = {key_reg, nv_reg};
                res_next   = nv_reg;
                state_next = S_FINISH;
            end

            // Load the result word once the output register is free
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    rsp_next.read_value  = res_reg;
                    rsp_next.found       = found_reg;
                    rsp_next.status      = status_reg;
                    rsp_next.entry_count = count32[ECOUNT_W-1:0];
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/ssvs_store_checker.sv =====
// Checker for the sorted sparse vector store: predicts every result word and compares.
// Depends on ssvs_pkg and the channel interfaces in ssvs_if.sv; watches, never drives.
`default_nettype none

module ssvs_store_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    ssvs_req_if                                  req,
    ssvs_rsp_if                                  rsp,
    input  wire logic                            cfg_we,
    input  wire logic [ssvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ssvs_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                   mismatch_count,
    output int                                   awaited_count
);
    import ssvs_pkg::*;

    localparam int    SLOTS     = CAPACITY_DEF;
    localparam longint VALUE_MAX = 64'sd2147483647;
    localparam longint VALUE_MIN = -64'sd2147483648;

    // Shadow copy of the pair store and its registers
    logic [POSITION_W-1:0]     key_mem [SLOTS];
    logic signed [VALUE_W-1:0] val_mem [SLOTS];
    int                        held;
    logic [DIM_W-1:0]          dim_reg;
    logic signed [VALUE_W-1:0] scale_reg;

    ssvs_rsp_t awaited_results [$];

    // Q16.16 scaled add: exact product, floor shift, saturate the sum
    function automatic logic signed [VALUE_W-1:0] saturated_scaled_sum(
        input logic signed [VALUE_W-1:0] old_value,
        input logic signed [VALUE_W-1:0] scale,
        input logic signed [VALUE_W-1:0] operand
    );
        longint prod;
        longint total;
        prod  = longint'(scale) * longint'(operand);
        total = longint'(old_value) + (prod >>> 16);
        if (total > VALUE_MAX)
            return 32'sh7FFFFFFF;
        if (total < VALUE_MIN)
            return 32'sh80000000;
        return total[VALUE_W-1:0];
    endfunction

    // Apply one request word to the shadow store and return its result word
    function automatic ssvs_rsp_t store_access(input ssvs_req_t r);
        ssvs_rsp_t                 o;
        int                        slot;
        int                        k;
        bit                        hit;
        logic signed [VALUE_W-1:0] old_value;
        logic signed [VALUE_W-1:0] new_value;
        o = '0;
        if (r.action == ACT_CLEAR)
        begin
            held = 0;
        end
        else if ({1'b0, r.position} >= dim_reg)
        begin
            o.status = STATUS_RANGE;
        end
        else
        begin
            slot = 0;
            while (slot < held && key_mem[slot] < r.position)
                slot++;
            hit = (slot < held) && (key_mem[slot] == r.position);
            o.found = hit;
            if (r.action == ACT_SET || r.action == ACT_ADD)
            begin
                old_value = hit ? val_mem[slot] : '0;
                new_value = (r.action == ACT_SET) ? r.operand
                          : saturated_scaled_sum(old_value, scale_reg, r.operand);
                if (hit)
                begin
                    val_mem[slot] = new_value;
                    o.read_value  = new_value;
                end
                else if (held >= SLOTS)
                begin
                    o.status = STATUS_FULL;
                end
                else
                begin
                    // open a gap at the sorted slot
                    for (k = held; k > slot; k--)
                    begin
                        key_mem[k] = key_mem[k-1];
                        val_mem[k] = val_mem[k-1];
                    end
                    key_mem[slot] = r.position;
                    val_mem[slot] = new_value;
                    held++;
                    o.read_value = new_value;
                end
            end
            else if (r.action == ACT_REMOVE)
            begin
                if (hit)
                begin
                    // close the gap
                    for (k = slot; k + 1 < held; k++)
                    begin
                        key_mem[k] = key_mem[k+1];
                        val_mem[k] = val_mem[k+1];
                    end
                    held--;
                end
            end
            else
            begin
                // get, and the unused codes behave like get
                o.read_value = hit ? val_mem[slot] : '0;
            end
        end
        o.entry_count = held[ECOUNT_W-1:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input ssvs_rsp_t exp_w,
                                   input ssvs_rsp_t got_w);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected %h/%0d/%0d/%0d, got %h/%0d/%0d/%0d",
                     what, exp_w.read_value, exp_w.found, exp_w.status,
                     exp_w.entry_count, got_w.read_value, got_w.found,
                     got_w.status, got_w.entry_count);
    endtask

    // Track config writes, compare result words, then queue the prediction for a new request
    always @(posedge clk or negedge rst_n)
    begin
        ssvs_rsp_t exp_w;
        if (!rst_n)
        begin
            held      = 0;
            dim_reg   = DIMENSION_RST;
            scale_reg = ADD_SCALE_RST;
            awaited_results.delete();
            mismatch_count = 0;
            awaited_count  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DIMENSION)
                    dim_reg = cfg_data[DIM_W-1:0];
                else if (cfg_index == CFG_ADD_SCALE)
                    scale_reg = cfg_data;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("no request pending", '0, rsp.payload);
                end
                else
                begin
                    exp_w = awaited_results.pop_front();
                    if (rsp.payload.read_value !== exp_w.read_value
                        || rsp.payload.found !== exp_w.found
                        || rsp.payload.status !== exp_w.status
                        || rsp.payload.entry_count !== exp_w.entry_count)
                        report_mismatch("field", exp_w, rsp.payload);
                end
            end
            if (req.valid && req.ready)
                awaited_results.push_back(store_access(req.payload));
            awaited_count = awaited_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench top for the sorted sparse vector store: clock, reset, stimulus, verdict.
// Depends on ssvs_pkg, ssvs_if.sv, the store RTL and ssvs_store_checker.
`default_nettype none

module tb_top;
    import ssvs_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatch_count;
    int                    awaited_count;

    ssvs_req_if req_ch ();
    ssvs_rsp_if rsp_ch ();

    // Stimulus shaping; hold_off_left is shared with the receiver process
    bit               sender_idle;
    int               burst_left;
    int               hold_off_left;
    bit               fill_mode;
    logic [DIM_W-1:0] cur_dim;
    int               pool_base;
    int               pool_stride;
    int               pool_size;

    sorted_sparse_vector_store_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ssvs_store_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #20000000;
        $display("FAIL sorted_sparse_vector_store_unit");
        $finish;
    end

    // Receiver: switch between stall patterns, honor a requested long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int tick;
        rsp_ch.ready = 1'b0;
        mode_left    = 0;
        tick         = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_off_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_off_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= (tick % 5) != 0;
                    default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Offer one request word and hold it until the block takes it
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [POSITION_W-1:0] pos,
                             input logic [VALUE_W-1:0] opd);
        int        gap;
        ssvs_req_t w;
        if (sender_idle && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        w.action   = act;
        w.position = pos;
        w.operand  = opd;
        req_ch.payload <= w;
        req_ch.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every result word has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_count != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_registers(input logic [DIM_W-1:0] dim, input logic [VALUE_W-1:0] scale);
        drain_results();
        write_reg(CFG_DIMENSION, {{(CFG_DATA_W-DIM_W){1'b0}}, dim});
        write_reg(CFG_ADD_SCALE, scale);
        cur_dim = dim;
    endtask

    // Random requests: mostly pool keys so the store fills, plus wild and boundary keys
    task automatic send_random(input int count);
        int                    w;
        logic [ACTION_W-1:0]   act;
        logic [POSITION_W-1:0] pos;
        logic [VALUE_W-1:0]    opd;
        repeat (count)
        begin
            w = $urandom_range(0, 99);
            if (fill_mode)
                act = (w < 10) ? ACT_GET : (w < 55) ? ACT_SET : (w < 85) ? ACT_ADD
                    : (w < 95) ? ACT_REMOVE : ACT_CLEAR + 3'($urandom_range(1, 3));
            else
                act = (w < 25) ? ACT_GET : (w < 45) ? ACT_SET : (w < 62) ? ACT_ADD
                    : (w < 84) ? ACT_REMOVE : (w < 87) ? ACT_CLEAR
                    : (w < 97) ? ACT_GET : ACT_CLEAR + 3'($urandom_range(1, 3));
            w = $urandom_range(0, 99);
            if (w < 70)
                pos = 16'(pool_base + pool_stride * $urandom_range(0, pool_size - 1));
            else if (w < 85)
                pos = 16'($urandom);
            else
                pos = 16'(cur_dim - 1 + $urandom_range(0, 2));
            w = $urandom_range(0, 99);
            if (w < 50)
                opd = $urandom;
            else if (w < 60)
                opd = 32'h7FFFFFFF;
            else if (w < 70)
                opd = 32'h80000000;
            else if (w < 80)
                opd = '0;
            else
                opd = 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
            send_word(act, pos, opd);
        end
    endtask

    // Main sequence: reset, directed cases, then random phases over several settings
    initial
    begin
        int p;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        sender_idle    = 1'b1;
        burst_left     = 0;
        hold_off_left  = 0;
        fill_mode      = 1'b0;
        cur_dim        = DIMENSION_RST;
        pool_base      = 0;
        pool_stride    = 1;
        pool_size      = 64;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty store, both key extremes, overwrite, saturation both ways
        send_word(ACT_GET,    16'd0,     32'h00000000);
        send_word(ACT_REMOVE, 16'd5,     32'h00000000);
        send_word(ACT_SET,    16'd0,     32'h7FFFFFFF);
        send_word(ACT_SET,    16'd65535, 32'h80000000);
        send_word(ACT_SET,    16'd100,   32'h00010000);
        send_word(ACT_GET,    16'd100,   32'h00000000);
        send_word(ACT_GET,    16'd65535, 32'h00000000);
        send_word(ACT_SET,    16'd100,   32'hFFFF0000);
        send_word(ACT_ADD,    16'd0,     32'h7FFFFFFF);
        send_word(ACT_ADD,    16'd65535, 32'h80000000);
        // add to an absent key creates a pair even when the sum is zero
        send_word(ACT_ADD,    16'd200,   32'h00000000);
        send_word(ACT_CLEAR + 3'd1, 16'd0,   32'hFFFFFFFF);
        send_word(ACT_CLEAR + 3'd3, 16'd100, 32'h12345678);
        send_word(ACT_REMOVE, 16'd100,   32'h00000000);
        send_word(ACT_GET,    16'd100,   32'h00000000);
        // half scale: negative products round toward minus infinity
        set_registers(DIMENSION_RST, 32'h00008000);
        send_word(ACT_ADD,    16'd300,   32'hFFFFFFFF);
        send_word(ACT_ADD,    16'd300,   32'h00000003);
        // range checks at and below the dimension, far beyond it, and a zero dimension
        set_registers(17'd1000, 32'h00008000);
        send_word(ACT_GET,    16'd1000,  32'h00000000);
        send_word(ACT_SET,    16'd999,   32'h00000042);
        send_word(ACT_REMOVE, 16'd5000,  32'h00000000);
        set_registers(17'd0, ADD_SCALE_RST);
        send_word(ACT_GET,    16'd0,     32'h00000000);
        set_registers(DIMENSION_RST, ADD_SCALE_RST);
        send_word(ACT_CLEAR,  16'hFFFF,  32'hFFFFFFFF);
        send_word(ACT_GET,    16'd0,     32'h00000000);

        // random phases, each with its own registers and key pool
        for (p = 0; p < 8; p++)
        begin
            sender_idle = 1'b1;
            pool_base   = $urandom_range(0, 65535);
            pool_stride = 1;
            pool_size   = 96;
            case (p)
                0:
                begin
                    set_registers(DIMENSION_RST, ADD_SCALE_RST);
                    fill_mode = 1'b1;
                    pool_size = 80;
                end
                1:
                begin
                    set_registers(DIMENSION_RST, 32'h7FFFFFFF);
                    fill_mode   = 1'b0;
                    pool_stride = 257;
                end
                2:
                begin
                    set_registers(17'd1, 32'h80000000);
                    fill_mode = 1'b0;
                    pool_base = 0;
                    pool_size = 4;
                end
                3:
                begin
                    set_registers(17'd200, 32'h00000000);
                    fill_mode = 1'b1;
                    pool_base = 150;
                    pool_size = 70;
                end
                4:
                begin
                    set_registers(17'd64, 32'hFFFF0000);
                    fill_mode = 1'b1;
                    pool_base = 0;
                    pool_size = 70;
                end
                5:
                begin
                    set_registers(DIMENSION_RST, 32'h00008000);
                    fill_mode   = 1'b1;
                    sender_idle = 1'b0;
                    pool_stride = $urandom_range(1, 700);
                end
                6:
                begin
                    set_registers(17'($urandom_range(1, 65536)), $urandom);
                    fill_mode   = 1'b0;
                    pool_stride = $urandom_range(1, 40);
                end
                default:
                begin
                    set_registers(17'd65535, 32'h00000001);
                    fill_mode = 1'b0;
                    pool_base = 65400;
                    pool_size = 136;
                end
            endcase
            if (p == 1)
            begin
                // long receiver hold-off while requests keep coming
                send_random(50);
                hold_off_left = 600;
                send_random(150);
            end
            else
            begin
                send_random(200);
            end
        end

        drain_results();
        repeat (100) @(negedge clk);
        if (mismatch_count == 0 && awaited_count == 0)
            $display("PASS sorted_sparse_vector_store_unit");
        else
            $display("FAIL sorted_sparse_vector_store_unit");
        $finish;
    end

endmodule

`default_nettype wire
